// ===== sv/idmh_pkg.sv =====
// Shared constants for the indexed d-ary min-heap block.
`default_nettype none
package idmh_pkg;
  localparam int DEF_HEAP_CAPACITY = 256;
  localparam int DEF_ITEM_SPACE    = 256;
  localparam int DEF_PRIORITY_BITS = 16;

  // Operation codes carried in the kind field
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;
  localparam logic [1:0] OP_PEEK   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  localparam logic [3:0] ARITY_MIN   = 4'd2;
  localparam logic [3:0] ARITY_MAX   = 4'd8;
  localparam logic [3:0] ARITY_RESET = 4'd2;
endpackage
`default_nettype wire

// ===== sv/indexed_dary_min_heap_top.sv =====
// Indexed d-ary min-heap priority queue, top level with its sequencer and memories.
//
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------------
//  in       | in_valid / in_ready | in_kind, in_item_id, in_priority_req
//  out      | out_valid/out_ready | out_top_item, out_top_priority, out_top_valid,
//           |                     | out_status, out_item_count
//  cfg      | cfg_we              | cfg_wdata (arity, used clamped to 2..8)
//
// An add, remove or update walks the heap one level at a time: sift-up reads one
// parent per level and sift-down reads each child of a level in turn, all through
// the single heap memory read port.
// After reset the present-bit memory is swept clear while in_ready stays low.
// A finished result waits in the output register; the next item is accepted
// meanwhile and only its final write-back stalls on out_ready.
`default_nettype none
module indexed_dary_min_heap_top
  import idmh_pkg::*;
#(
  parameter int HEAP_CAPACITY = DEF_HEAP_CAPACITY,
  parameter int ITEM_SPACE    = DEF_ITEM_SPACE,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_kind,
  input  wire logic [7:0]  in_item_id,
  input  wire logic [15:0] in_priority_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_top_item,
  output logic [15:0]      out_top_priority,
  output logic             out_top_valid,
  output logic [2:0]       out_status,
  output logic [8:0]       out_item_count,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata
);
  localparam int PB     = PRIORITY_BITS;
  localparam int POS_W  = $clog2(HEAP_CAPACITY);
  localparam int CNT_W  = $clog2(HEAP_CAPACITY + 1);
  localparam int ID_W   = $clog2(ITEM_SPACE);
  localparam int CW     = POS_W + 4;          // child index, may run past capacity
  localparam int SH     = POS_W + 4;          // reciprocal scale
  localparam int PW     = POS_W + SH;         // product width
  // ceil(2^SH / d): exact quotient of (pos-1)/d for every position
  localparam int RCP2 = (2**SH + 1) / 2;
  localparam int RCP3 = (2**SH + 2) / 3;
  localparam int RCP4 = (2**SH + 3) / 4;
  localparam int RCP5 = (2**SH + 4) / 5;
  localparam int RCP6 = (2**SH + 5) / 6;
  localparam int RCP7 = (2**SH + 6) / 7;
  localparam int RCP8 = (2**SH + 7) / 8;

  // Sequencer states
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_DECIDE  = 4'd2;
  localparam logic [3:0] S_RM_TOP  = 4'd3;
  localparam logic [3:0] S_RM_LAST = 4'd4;
  localparam logic [3:0] S_SUP     = 4'd5;
  localparam logic [3:0] S_SUP_RD  = 4'd6;
  localparam logic [3:0] S_SUP_CMP = 4'd7;
  localparam logic [3:0] S_SDN     = 4'd8;
  localparam logic [3:0] S_SDN_RD  = 4'd9;
  localparam logic [3:0] S_SDN_CMP = 4'd10;
  localparam logic [3:0] S_PLACE   = 4'd11;
  localparam logic [3:0] S_TOP_RD  = 4'd12;
  localparam logic [3:0] S_FIN     = 4'd13;

  function automatic logic key_less(input logic [PB-1:0] a_pr, input logic [7:0] a_id,
                                    input logic [PB-1:0] b_pr, input logic [7:0] b_id);
    key_less = (a_pr < b_pr) || ((a_pr == b_pr) && (a_id < b_id));
  endfunction

  // Memories
  logic [7:0]      heap_id_mem [HEAP_CAPACITY];
  logic [PB-1:0]   heap_pr_mem [HEAP_CAPACITY];
  logic [POS_W-1:0] pos_mem    [ITEM_SPACE];
  logic            pres_mem    [ITEM_SPACE];

  // Control state
  logic [3:0]       state_r, state_nxt;
  logic [ID_W-1:0]  clr_r, clr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]       arity_r;
  logic             out_valid_r, out_valid_nxt;

  // Working registers
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       e_id_r, e_id_nxt;
  logic [PB-1:0]    e_pr_r, e_pr_nxt;
  logic             in_space_r, in_space_nxt;
  logic [2:0]       status_r, status_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] par_r, par_nxt;
  logic [PW-1:0]    prod_r, prod_nxt;
  logic [CW-1:0]    child_r, child_nxt;
  logic [3:0]       k_r, k_nxt;
  logic [CW-1:0]    best_idx_r, best_idx_nxt;
  logic [7:0]       best_id_r, best_id_nxt;
  logic [PB-1:0]    best_pr_r, best_pr_nxt;

  // Result register
  logic [7:0]  o_item_r, o_item_nxt;
  logic [15:0] o_pr_r, o_pr_nxt;
  logic        o_tv_r, o_tv_nxt;
  logic [2:0]  o_st_r, o_st_nxt;
  logic [8:0]  o_cnt_r, o_cnt_nxt;

  // Memory ports
  logic             hw_en;
  logic [POS_W-1:0] hw_addr, hr_addr;
  logic [7:0]       hw_id, hrd_id;
  logic [PB-1:0]    hw_pr, hrd_pr;
  logic             pw_en;
  logic [ID_W-1:0]  pw_addr;
  logic [POS_W-1:0] pw_data, prd;
  logic             sw_en, sw_data, srd;
  logic [ID_W-1:0]  sw_addr;

  logic [3:0]    d;
  logic [SH-1:0] rcp;
  logic [31:0]   pr_ext;
  logic [31:0]   top_pr_ext;
  logic          accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign pr_ext   = 32'(in_priority_req);
  assign top_pr_ext = 32'(hrd_pr);

  // Clamp arity to 2..8
  always_comb begin
    if (arity_r < ARITY_MIN) begin
      d = ARITY_MIN;
    end else if (arity_r > ARITY_MAX) begin
      d = ARITY_MAX;
    end else begin
      d = arity_r;
    end
  end

  always_comb begin
    case (d)
      4'd2: rcp = SH'(RCP2);
      4'd3: rcp = SH'(RCP3);
      4'd4: rcp = SH'(RCP4);
      4'd5: rcp = SH'(RCP5);
      4'd6: rcp = SH'(RCP6);
      4'd7: rcp = SH'(RCP7);
      default: rcp = SH'(RCP8);
    endcase
  end

  // Heap memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_id_mem[hw_addr] <= hw_id;
      heap_pr_mem[hw_addr] <= hw_pr;
    end
    hrd_id <= heap_id_mem[hr_addr];
    hrd_pr <= heap_pr_mem[hr_addr];
  end

  // Position table and present bits, read at the incoming id
  always_ff @(posedge clk) begin
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    prd <= pos_mem[ID_W'(in_item_id)];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      pres_mem[sw_addr] <= sw_data;
    end
    srd <= pres_mem[ID_W'(in_item_id)];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    e_id_nxt      = e_id_r;
    e_pr_nxt      = e_pr_r;
    in_space_nxt  = in_space_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    par_nxt       = par_r;
    prod_nxt      = prod_r;
    child_nxt     = child_r;
    k_nxt         = k_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    best_pr_nxt   = best_pr_r;
    o_item_nxt    = o_item_r;
    o_pr_nxt      = o_pr_r;
    o_tv_nxt      = o_tv_r;
    o_st_nxt      = o_st_r;
    o_cnt_nxt     = o_cnt_r;
    hw_en   = 1'b0;
    hw_addr = pos_r;
    hw_id   = e_id_r;
    hw_pr   = e_pr_r;
    hr_addr = '0;
    pw_en   = 1'b0;
    pw_addr = ID_W'(e_id_r);
    pw_data = pos_r;
    sw_en   = 1'b0;
    sw_addr = ID_W'(e_id_r);
    sw_data = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        sw_en   = 1'b1;
        sw_addr = clr_r;
        sw_data = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ID_W'(ITEM_SPACE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_nxt     = in_kind;
          e_id_nxt     = in_item_id;
          e_pr_nxt     = pr_ext[PB-1:0];
          in_space_nxt = (32'(in_item_id) < ITEM_SPACE);
          status_nxt   = ST_OK;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (kind_r)
          OP_ADD: begin
            if (in_space_r && srd) begin
              status_nxt = ST_PRESENT;
              state_nxt  = S_TOP_RD;
            end else if (!in_space_r || cnt_r == CNT_W'(HEAP_CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_TOP_RD;
            end else begin
              sw_en     = 1'b1;
              sw_data   = 1'b1;
              pos_nxt   = cnt_r[POS_W-1:0];
              cnt_nxt   = cnt_r + 1'b1;
              state_nxt = S_SUP;
            end
          end
          OP_REMOVE: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_TOP_RD;
            end else begin
              hr_addr   = '0;
              state_nxt = S_RM_TOP;
            end
          end
          OP_UPDATE: begin
            if (!in_space_r || !srd || CNT_W'(prd) >= cnt_r) begin
              status_nxt = ST_ABSENT;
              state_nxt  = S_TOP_RD;
            end else begin
              pos_nxt   = prd;
              state_nxt = S_SUP;
            end
          end
          default: begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end
            state_nxt = S_TOP_RD;
          end
        endcase
      end
      S_RM_TOP: begin
        // Clear the old top's present bit, fetch the last entry
        sw_en     = 1'b1;
        sw_addr   = ID_W'(hrd_id);
        sw_data   = 1'b0;
        hr_addr   = POS_W'(cnt_r - 1'b1);
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = S_RM_LAST;
      end
      S_RM_LAST: begin
        if (cnt_r == '0) begin
          state_nxt = S_TOP_RD;
        end else begin
          e_id_nxt  = hrd_id;
          e_pr_nxt  = hrd_pr;
          pos_nxt   = '0;
          state_nxt = S_SDN;
        end
      end
      S_SUP: begin
        if (pos_r == '0) begin
          state_nxt = (kind_r == OP_UPDATE) ? S_SDN : S_PLACE;
        end else begin
          prod_nxt  = PW'(pos_r - 1'b1) * PW'(rcp);
          state_nxt = S_SUP_RD;
        end
      end
      S_SUP_RD: begin
        hr_addr   = prod_r[SH +: POS_W];
        par_nxt   = prod_r[SH +: POS_W];
        state_nxt = S_SUP_CMP;
      end
      S_SUP_CMP: begin
        if (key_less(e_pr_r, e_id_r, hrd_pr, hrd_id)) begin
          // Move the parent down into the hole
          hw_en     = 1'b1;
          hw_id     = hrd_id;
          hw_pr     = hrd_pr;
          pw_en     = 1'b1;
          pw_addr   = ID_W'(hrd_id);
          pos_nxt   = par_r;
          state_nxt = S_SUP;
        end else begin
          state_nxt = (kind_r == OP_UPDATE) ? S_SDN : S_PLACE;
        end
      end
      S_SDN: begin
        child_nxt    = CW'(pos_r) * CW'(d) + CW'(1);
        k_nxt        = '0;
        best_idx_nxt = CW'(pos_r);
        best_id_nxt  = e_id_r;
        best_pr_nxt  = e_pr_r;
        state_nxt    = S_SDN_RD;
      end
      S_SDN_RD: begin
        if (k_r == d || child_r >= CW'(cnt_r)) begin
          if (best_idx_r == CW'(pos_r)) begin
            state_nxt = S_PLACE;
          end else begin
            // Move the smallest child up into the hole
            hw_en     = 1'b1;
            hw_id     = best_id_r;
            hw_pr     = best_pr_r;
            pw_en     = 1'b1;
            pw_addr   = ID_W'(best_id_r);
            pos_nxt   = best_idx_r[POS_W-1:0];
            state_nxt = S_SDN;
          end
        end else begin
          hr_addr   = child_r[POS_W-1:0];
          state_nxt = S_SDN_CMP;
        end
      end
      S_SDN_CMP: begin
        if (key_less(hrd_pr, hrd_id, best_pr_r, best_id_r)) begin
          best_idx_nxt = child_r;
          best_id_nxt  = hrd_id;
          best_pr_nxt  = hrd_pr;
        end
        child_nxt = child_r + 1'b1;
        k_nxt     = k_r + 1'b1;
        state_nxt = S_SDN_RD;
      end
      S_PLACE: begin
        hw_en     = 1'b1;
        pw_en     = 1'b1;
        state_nxt = S_TOP_RD;
      end
      S_TOP_RD: begin
        hr_addr   = '0;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold until the result register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_tv_nxt      = (cnt_r != '0);
          o_item_nxt    = (cnt_r != '0) ? hrd_id : 8'd0;
          o_pr_nxt      = (cnt_r != '0) ? top_pr_ext[15:0] : 16'd0;
          o_st_nxt      = status_r;
          o_cnt_nxt     = 9'(cnt_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      arity_r     <= ARITY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        arity_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    e_id_r     <= e_id_nxt;
    e_pr_r     <= e_pr_nxt;
    in_space_r <= in_space_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
    par_r      <= par_nxt;
    prod_r     <= prod_nxt;
    child_r    <= child_nxt;
    k_r        <= k_nxt;
    best_idx_r <= best_idx_nxt;
    best_id_r  <= best_id_nxt;
    best_pr_r  <= best_pr_nxt;
    o_item_r   <= o_item_nxt;
    o_pr_r     <= o_pr_nxt;
    o_tv_r     <= o_tv_nxt;
    o_st_r     <= o_st_nxt;
    o_cnt_r    <= o_cnt_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_top_item     = o_item_r;
  assign out_top_priority = o_pr_r;
  assign out_top_valid    = o_tv_r;
  assign out_status       = o_st_r;
  assign out_item_count   = o_cnt_r;
endmodule
`default_nettype wire

// ===== sv/idmh_checker.sv =====
// Port-level checks for the heap block and their binding to the top level.
`default_nettype none
module idmh_checker
  import idmh_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_top_item,
  input wire logic [15:0] out_top_priority,
  input wire logic        out_top_valid,
  input wire logic [2:0]  out_status,
  input wire logic [8:0]  out_item_count
);
  a_top_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_valid == (out_item_count != 9'd0)))
    else $error("top_valid disagrees with item count");

  a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_top_valid) |-> (out_top_item == 8'd0 && out_top_priority == 16'd0))
    else $error("empty heap reports a nonzero top");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_item_count == 9'd0))
    else $error("empty status with items held");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_top_item)
                                   && $stable(out_status) && $stable(out_item_count)))
    else $error("result changed while stalled");
endmodule

bind indexed_dary_min_heap_top idmh_checker u_idmh_checker (.*);
`default_nettype wire
